FILE: rtl/html_tag_entity_stripper_unit_macros.svh
// ----------------------------------------------------------------------------
// HTML tag and entity stripper assertion macros
// Shared concurrent check forms for the stripper block.
// ----------------------------------------------------------------------------
`ifndef HTML_TAG_ENTITY_STRIPPER_UNIT_MACROS_SVH
`define HTML_TAG_ENTITY_STRIPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTES_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/htes_pkg.sv
// ----------------------------------------------------------------------------
// HTES package
// Character codes, entity pattern table and the burst descriptor type.
// ----------------------------------------------------------------------------
package htes_pkg;

    localparam int CH_W  = 8;
    localparam int CNT_W = 3;

    localparam logic [CNT_W-1:0] ENT_LAST_IDX = 3'd5;

    localparam logic [CH_W-1:0] CH_LT   = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT   = 8'h3E;
    localparam logic [CH_W-1:0] CH_AMP  = 8'h26;
    localparam logic [CH_W-1:0] CH_HASH = 8'h23;
    localparam logic [CH_W-1:0] CH_N    = 8'h6E;
    localparam logic [CH_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [CH_W-1:0] CH_LF   = 8'h0A;

    localparam logic PAT_NUMERIC = 1'b0;
    localparam logic PAT_NBSP    = 1'b1;

    // One accepted character's worth of output: a run of held pattern
    // characters, then an optional tail character, or an end marker at string end if both are empty.
    typedef struct packed {
        logic [CNT_W-1:0] rel_cnt;
        logic             rel_pat;
        logic             tail_valid;
        logic [CH_W-1:0]  tail_ch;
        logic             last;
        logic [CNT_W-1:0] total;
    } htes_desc_t;

    function automatic logic [CH_W-1:0] ent_char(input logic pat, input logic [CNT_W-1:0] idx);
        logic [CH_W-1:0] c;
        c = CH_SEMI;
        if (pat == PAT_NUMERIC)
        begin
            case (idx)
                3'd0:    c = CH_AMP;
                3'd1:    c = CH_HASH;
                3'd2:    c = 8'h31;
                3'd3:    c = 8'h36;
                3'd4:    c = 8'h30;
                default: c = CH_SEMI;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    c = CH_AMP;
                3'd1:    c = CH_N;
                3'd2:    c = 8'h62;
                3'd3:    c = 8'h73;
                3'd4:    c = 8'h70;
                default: c = CH_SEMI;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: rtl/htes_if.sv
// ----------------------------------------------------------------------------
// HTES stream interfaces
// Valid/ready channels for input characters and output results.
// ----------------------------------------------------------------------------
interface htes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface htes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch_out;
    logic       has_char;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output ch_out, output has_char, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input ch_out, input has_char, input run_last,
                    input string_end, output ready);
endinterface

FILE: rtl/htes_classify.sv
// ----------------------------------------------------------------------------
// HTES classifier
// Holds tag/entity state and turns each accepted character into a descriptor.
// ----------------------------------------------------------------------------
module htes_classify (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            ch,
    input  logic                  last,
    output htes_pkg::htes_desc_t  desc
);
    import htes_pkg::*;

    logic             inside_reg, inside_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             pat_reg, pat_next;

    always_comb
    begin
        logic [CNT_W-1:0] h_eff;
        logic             fresh;
        logic [CNT_W-1:0] rel_cnt;
        logic             rel_pat;
        logic             tail_valid;
        logic             marker;

        h_eff       = (held_reg > ENT_LAST_IDX) ? '0 : held_reg;
        inside_next = inside_reg;
        held_next   = h_eff;
        pat_next    = pat_reg;
        rel_cnt     = '0;
        rel_pat     = pat_reg;
        fresh       = 1'b0;
        tail_valid  = 1'b0;

        if (inside_reg)
        begin
            if (ch == CH_GT)
                inside_next = 1'b0;
        end
        else if (h_eff == 3'd1)
        begin
            if (ch == CH_HASH)
            begin
                pat_next  = PAT_NUMERIC;
                held_next = 3'd2;
            end
            else if (ch == CH_N)
            begin
                pat_next  = PAT_NBSP;
                held_next = 3'd2;
            end
            else
            begin
                rel_cnt   = h_eff;
                held_next = '0;
                fresh     = 1'b1;
            end
        end
        else if (h_eff > 3'd1)
        begin
            if (ch == ent_char(pat_reg, h_eff))
                held_next = (h_eff == ENT_LAST_IDX) ? '0 : h_eff + 3'd1;
            else
            begin
                rel_cnt   = h_eff;
                held_next = '0;
                fresh     = 1'b1;
            end
        end
        else
        begin
            fresh = 1'b1;
        end

        if (fresh)
        begin
            case (ch)
                CH_LT:   inside_next = 1'b1;
                CH_AMP:  held_next   = 3'd1;
                CH_LF:   tail_valid  = 1'b0;
                default: tail_valid  = 1'b1;
            endcase
        end

        // Flush whatever is still held at end of string
        if (last)
        begin
            if (held_next != '0)
            begin
                if (rel_cnt == '0)
                begin
                    rel_cnt = held_next;
                    rel_pat = pat_next;
                end
                else
                begin
                    tail_valid = 1'b1;
                end
            end
            inside_next = 1'b0;
            held_next   = '0;
            pat_next    = PAT_NUMERIC;
        end

        marker = last && (rel_cnt == '0) && !tail_valid;

        desc.rel_cnt    = rel_cnt;
        desc.rel_pat    = rel_pat;
        desc.tail_valid = tail_valid;
        desc.tail_ch    = ch;
        desc.last       = last;
        desc.total      = rel_cnt + {{(CNT_W-1){1'b0}}, tail_valid}
                        + {{(CNT_W-1){1'b0}}, marker};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            held_reg   <= '0;
            pat_reg    <= PAT_NUMERIC;
        end
        else if (fire)
        begin
            inside_reg <= inside_next;
            held_reg   <= held_next;
            pat_reg    <= pat_next;
        end
    end

endmodule

FILE: rtl/htes_emit.sv
// ----------------------------------------------------------------------------
// HTES emitter
// Holds one descriptor and walks it out one result per cycle, while dout is ready, into a register.
// ----------------------------------------------------------------------------
module htes_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  htes_pkg::htes_desc_t  desc,
    output logic                  free,
    htes_out_if.source            dout
);
    import htes_pkg::*;

    logic             burst_valid_reg;
    htes_desc_t       burst_reg;
    logic [CNT_W-1:0] idx_reg;

    logic             out_valid_reg;
    logic [CH_W-1:0]  ch_out_reg;
    logic             has_char_reg;
    logic             run_last_reg;
    logic             string_end_reg;

    logic             out_load;
    logic             item_final;
    logic [CH_W-1:0]  item_ch;
    logic             item_has;

    assign out_load   = burst_valid_reg && (!out_valid_reg || dout.ready);
    assign item_final = (idx_reg == burst_reg.total - 3'd1);
    assign free       = !burst_valid_reg || (out_load && item_final);

    always_comb
    begin
        if (idx_reg < burst_reg.rel_cnt)
        begin
            item_ch  = ent_char(burst_reg.rel_pat, idx_reg);
            item_has = 1'b1;
        end
        else if (burst_reg.tail_valid)
        begin
            item_ch  = burst_reg.tail_ch;
            item_has = 1'b1;
        end
        else
        begin
            item_ch  = '0;
            item_has = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else if (load)
        begin
            burst_valid_reg <= 1'b1;
            idx_reg         <= '0;
        end
        else if (out_load)
        begin
            if (item_final)
                burst_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ch_out_reg     <= item_ch;
            has_char_reg   <= item_has;
            run_last_reg   <= item_final;
            string_end_reg <= item_final && burst_reg.last;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.ch_out     = ch_out_reg;
    assign dout.has_char   = has_char_reg;
    assign dout.run_last   = run_last_reg;
    assign dout.string_end = string_end_reg;

endmodule

FILE: rtl/html_tag_entity_stripper_unit.sv
// A character's first result goes through the descriptor register, then the output register, to dout.
// Throughput: one character per cycle while each yields at most one result and dout is ready;
// a character with up to six results holds the descriptor register until its last is registered.
// Reset: rst_n clears tag and entity state and all valid flags at once.
// ----------------------------------------------------------------------------
// HTML tag and entity stripper
// Drops tags, &#160; / &nbsp; entities and newlines from a character stream.
// ----------------------------------------------------------------------------
`include "html_tag_entity_stripper_unit_macros.svh"

module html_tag_entity_stripper_unit (
    input  logic         clk,
    input  logic         rst_n,
    htes_in_if.sink      din,
    htes_out_if.source   dout
);
    import htes_pkg::*;

    htes_desc_t desc;
    logic       free;
    logic       fire;

    assign din.ready = free;
    assign fire      = din.valid && din.ready;

    htes_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (din.ch),
        .last  (din.last),
        .desc  (desc)
    );

    htes_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire && (desc.total != '0)),
        .desc  (desc),
        .free  (free),
        .dout  (dout)
    );

    `HTES_ASSERT_IMPLY(a_last_closes, clk, rst_n, fire && din.last, desc.total != '0, "string end produced no result")
    `HTES_ASSERT_IMPLY(a_total_bound, clk, rst_n, fire, desc.total <= 3'd6, "burst longer than six results")
    `HTES_ASSERT_IMPLY(a_end_is_run_last, clk, rst_n, dout.valid && dout.string_end, dout.run_last, "string end not on last result")
    `HTES_ASSERT_IMPLY(a_marker_empty, clk, rst_n, dout.valid && !dout.has_char, dout.string_end && (dout.ch_out == '0), "empty result outside string end")

endmodule
